/* rtl/u2da_pkg.sv */
// Package for the unsigned binary to decimal ASCII converter.
// Holds the fixed widths, character constants and the sequencer state type.
// No dependencies.
package u2da_pkg;

  localparam int unsigned DataW     = 32;
  localparam int unsigned NumDigits = 10;
  localparam int unsigned BcdW      = 4 * NumDigits;
  localparam int unsigned CharW     = 6;
  localparam int unsigned CountW    = 4;
  localparam int unsigned IterW     = $clog2(DataW);
  localparam int unsigned OutDataW  = 16;

  localparam logic [CharW-1:0] DigitBase = CharW'(48);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CONV  = 4'b0010,
    ST_COUNT = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

endpackage

/* rtl/unsigned_to_decimal_ascii.sv */
// Operation: a word accepted on the input is converted by shift-add-3 over all 32 bits,
// one bit per cycle through one shared shift/adjust unit, then the count state finds the
// digit count, and the emit state loads the characters into the output word register.
// Output: n = 1..10 characters per value, one character a cycle while m_tready allows;
// a new value is taken only after the last character is loaded. Reset (rst, synchronous):
// sequencer to idle, output word invalid. Depends on u2da_pkg.
module unsigned_to_decimal_ascii
  import u2da_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [DataW-1:0]    s_tdata,   // [31:0] value
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OutDataW-1:0] m_tdata,   // [5:0] ascii_char, [9:6] digit_count, [15:10] zero
  output logic                m_tlast    // is_last
);

  state_t              state, state_next;
  logic [DataW-1:0]    bin;
  logic [BcdW-1:0]     bcd;
  logic [BcdW-1:0]     bcd_adj;
  logic [IterW-1:0]    iter;
  logic [CountW-1:0]   count;
  logic [CountW-1:0]   count_next;
  logic [CountW-1:0]   idx;
  logic [CharW-1:0]    ascii_char;
  logic [CountW-1:0]   digit_count;
  logic                load_out;

  // add-3 on every BCD digit at 5 or above, ahead of the shift
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  // highest non-zero digit sets the count; zero still gives one character
  always_comb begin
    count_next = CountW'(1);
    for (int i = 1; i < NumDigits; i++) begin
      if (bcd[4*i +: 4] != 4'd0) begin
        count_next = CountW'(i + 1);
      end
    end
  end

  assign s_tready = (state == ST_IDLE);
  assign load_out = (state == ST_EMIT) && (!m_tvalid || m_tready);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (s_tvalid) state_next = ST_CONV;
      ST_CONV:  if (iter == IterW'(DataW - 1)) state_next = ST_COUNT;
      ST_COUNT: state_next = ST_EMIT;
      ST_EMIT:  if (load_out && idx == '0) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        bin  <= s_tdata;
        bcd  <= '0;
        iter <= '0;
      end
      ST_CONV: begin
        {bcd, bin} <= {bcd_adj[BcdW-2:0], bin, 1'b0};
        iter       <= iter + IterW'(1);
      end
      ST_COUNT: begin
        count <= count_next;
        idx   <= count_next - CountW'(1);
      end
      ST_EMIT: begin
        if (load_out && idx != '0) idx <= idx - CountW'(1);
      end
      default: begin
      end
    endcase
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      ascii_char  <= DigitBase | CharW'(bcd[4*idx +: 4]);
      digit_count <= count;
      m_tlast     <= (idx == '0);
    end
  end

  assign m_tdata = {{(OutDataW - CharW - CountW){1'b0}}, digit_count, ascii_char};

  a_accept_starts_conv: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == ST_CONV)
    else $error("accepted word did not start conversion");

  a_conv_runs_full: assert property (@(posedge clk) disable iff (rst)
    state == ST_CONV && iter != IterW'(DataW - 1) |=> state == ST_CONV)
    else $error("conversion left early");

  a_char_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ascii_char >= CharW'(48) && ascii_char <= CharW'(57))
    else $error("character out of digit range");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> digit_count >= CountW'(1) && digit_count <= CountW'(NumDigits))
    else $error("digit count out of range");

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    load_out && idx == '0 |=> state == ST_IDLE && m_tlast)
    else $error("final character did not close the run");

endmodule

/* verif/tb.sv */
// Self-checking bench for unsigned_to_decimal_ascii: drives 32-bit values on the
// input stream and checks each ASCII digit word against a built-in predictor.
// Depends on u2da_pkg and the RTL top level.
module tb;
  import u2da_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandomValues = 138;
  localparam int unsigned HoldCycles   = 600;
  localparam int unsigned StallLimit   = 3000;
  localparam int unsigned DrainCycles  = 60;

  typedef struct packed {
    logic [CharW-1:0]  ch;
    logic [CountW-1:0] cnt;
    logic              last;
  } dec_char_t;

  class digit_text_board;
    dec_char_t   pending_chars[$];
    int unsigned failures;
    int unsigned values_seen;
    int unsigned chars_checked;
    int unsigned count_hits[NumDigits+1];

    // Splits the value into decimal digits and queues them most significant first.
    function void queue_decimal_text(logic [DataW-1:0] value);
      logic [3:0]  digs[NumDigits];
      logic [DataW-1:0] rest;
      int          n;
      dec_char_t   c;
      rest = value;
      n    = 0;
      do begin
        digs[n] = 4'(rest % 10);
        rest    = rest / 10;
        n++;
      end while (rest != 0 && n < NumDigits);
      for (int k = 0; k < n; k++) begin
        c.ch   = DigitBase + CharW'(digs[n-1-k]);
        c.cnt  = CountW'(n);
        c.last = (k == n - 1);
        pending_chars.push_back(c);
      end
      values_seen++;
      count_hits[n]++;
    endfunction

    function void check_char(logic [OutDataW-1:0] data, logic last);
      dec_char_t got, want;
      got.ch   = data[CharW-1:0];
      got.cnt  = data[CharW+CountW-1:CharW];
      got.last = last;
      chars_checked++;
      if (pending_chars.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("%0t: unexpected word: char %0d count %0d last %0b",
                   $realtime, got.ch, got.cnt, got.last);
        return;
      end
      want = pending_chars.pop_front();
      if (got !== want) begin
        failures++;
        if (failures <= 10)
          $display("%0t: mismatch: exp char %0d count %0d last %0b, %s %0d %0d %0b",
                   $realtime, want.ch, want.cnt, want.last, "got char/count/last",
                   got.ch, got.cnt, got.last);
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [DataW-1:0]    s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic                m_tlast;

  digit_text_board board = new();
  bit          quiet;
  bit          hold_done;
  int unsigned quiet_cycles;

  always #5 clk = ~clk;

  unsigned_to_decimal_ascii uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // mostly short gaps, a few long ones, none at all in quiet stretches
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 70);
  endfunction

  task automatic send_value(logic [DataW-1:0] value);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    do @(posedge clk); while (!s_tready);
  endtask

  // monitors and stall watchdog
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (s_tvalid && s_tready) board.queue_decimal_text(s_tdata);
      if (m_tvalid && m_tready) board.check_char(m_tdata, m_tlast);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= StallLimit) begin
        $display("%0t: no word moved for %0d cycles", $realtime, StallLimit);
        $display("status: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // receiver: random ready runs and stalls, plus one long hold-off
  initial begin
    int unsigned gap;
    @(negedge rst);
    forever begin
      if (!hold_done && board.chars_checked >= 150) begin
        hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin
    logic [DataW-1:0] directed[];
    longint unsigned p, lo, hi;
    int unsigned     n, sel;
    logic [DataW-1:0] v;

    directed = '{
      32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd12345, 32'd9999, 32'd10000,
      32'd999999999, 32'd1000000000, 32'd1000000001, 32'd4294967295, 32'd4294967294,
      32'd2147483647, 32'd2147483648, 32'h5555_5555, 32'hAAAA_AAAA, 32'd4000000000,
      32'd3999999999, 32'd8, 32'd90
    };

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) send_value(directed[i]);

    for (int i = 0; i < RandomValues; i++) begin
      quiet = (i >= 40 && i < 80);
      sel = $urandom_range(0, 9);
      if (sel <= 5) begin
        // pick a digit count first so short and long numbers are equally likely
        n = $urandom_range(1, NumDigits);
        p = 1;
        repeat (n - 1) p = p * 10;
        lo = (n == 1) ? 0 : p;
        hi = p * 10 - 1;
        if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
        v = DataW'(lo + $urandom_range(0, 32'(hi - lo)));
      end else if (sel <= 7) begin
        v = $urandom();
      end else if (sel == 8) begin
        // just below, at or just above a power of ten
        p = 1;
        repeat ($urandom_range(1, 9)) p = p * 10;
        v = DataW'(p + $urandom_range(0, 2) - 1);
      end else begin
        v = $urandom_range(0, 20);
      end
      send_value(v);
    end
    quiet = 1'b0;
    s_tvalid <= 1'b0;

    while (board.pending_chars.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("converted %0d values to %0d digit words, with one long output hold-off",
             board.values_seen, board.chars_checked);
    $display("lengths 1..10 seen %0d/%0d/%0d/%0d/%0d/%0d/%0d/%0d/%0d/%0d times",
             board.count_hits[1], board.count_hits[2], board.count_hits[3],
             board.count_hits[4], board.count_hits[5], board.count_hits[6],
             board.count_hits[7], board.count_hits[8], board.count_hits[9],
             board.count_hits[10]);
    $display("mismatched or unexpected words: %0d", board.failures);
    if (board.failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
